// ===== design/vmd_pkg.sv =====
// Shared types and constants for the volume mip box downsampler.
package vmd_pkg;

	localparam int unsigned ChanW  = 32;
	localparam int unsigned SumW   = 35;
	localparam int unsigned NumCh  = 4;
	localparam int unsigned DimW   = 8;
	localparam int unsigned CcntW  = 3;

	typedef enum logic [1:0] {
		REG_HALF_WIDTH    = 2'd0,
		REG_HALF_HEIGHT   = 2'd1,
		REG_HALF_DEPTH    = 2'd2,
		REG_CHANNEL_COUNT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [ChanW-1:0] chan_a;
		logic signed [ChanW-1:0] chan_b;
		logic signed [ChanW-1:0] chan_c;
		logic signed [ChanW-1:0] chan_d;
	} in_item_t;

	typedef struct packed {
		logic signed [ChanW-1:0] avg_a;
		logic signed [ChanW-1:0] avg_b;
		logic signed [ChanW-1:0] avg_c;
		logic signed [ChanW-1:0] avg_d;
		logic                    level_done;
	} out_item_t;

	// Control word that the front hands to the back with each voxel.
	typedef struct packed {
		logic first;
		logic last;
		logic done;
	} vox_ctl_t;

endpackage

// ===== design/vmd_front.sv =====
// Front end: walks the source position and classifies each voxel request.
module vmd_front #(
	parameter int unsigned MaxHw = 128,
	parameter int unsigned MaxHh = 128,
	parameter int unsigned MaxHd = 128,
	parameter int unsigned XW    = 8,
	parameter int unsigned YW    = 8,
	parameter int unsigned ZW    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [vmd_pkg::DimW-1:0]      half_width,
	input  logic [vmd_pkg::DimW-1:0]      half_height,
	input  logic [vmd_pkg::DimW-1:0]      half_depth,
	input  logic                          step,
	output logic [XW-2:0]                 dst_x,
	output logic [YW-2:0]                 dst_y,
	output vmd_pkg::vox_ctl_t             ctl
);
	import vmd_pkg::*;

	logic [XW-1:0] pos_x_q;
	logic [YW-1:0] pos_y_q;
	logic [ZW-1:0] pos_z_q;
	logic [XW-1:0] lim_x;
	logic [YW-1:0] lim_y;
	logic [ZW-1:0] lim_z;
	logic          end_x, end_y, end_z;

	// clamp a half dimension to 1..max, then give the last source coordinate
	always_comb begin
		if (half_width == '0) lim_x = XW'(1);
		else if (32'(half_width) > MaxHw) lim_x = XW'(2*MaxHw-1);
		else lim_x = XW'({half_width, 1'b0} - 9'd1);
		if (half_height == '0) lim_y = YW'(1);
		else if (32'(half_height) > MaxHh) lim_y = YW'(2*MaxHh-1);
		else lim_y = YW'({half_height, 1'b0} - 9'd1);
		if (half_depth == '0) lim_z = ZW'(1);
		else if (32'(half_depth) > MaxHd) lim_z = ZW'(2*MaxHd-1);
		else lim_z = ZW'({half_depth, 1'b0} - 9'd1);
	end

	assign end_x = (pos_x_q == lim_x);
	assign end_y = (pos_y_q == lim_y);
	assign end_z = (pos_z_q == lim_z);

	assign dst_x     = pos_x_q[XW-1:1];
	assign dst_y     = pos_y_q[YW-1:1];
	assign ctl.first = ~(pos_x_q[0] | pos_y_q[0] | pos_z_q[0]);
	assign ctl.last  = pos_x_q[0] & pos_y_q[0] & pos_z_q[0];
	assign ctl.done  = ctl.last & end_x & end_y & end_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (step) begin
			if (end_x) begin
				pos_x_q <= '0;
				if (end_y) begin
					pos_y_q <= '0;
					pos_z_q <= end_z ? '0 : pos_z_q + ZW'(1);
				end else begin
					pos_y_q <= pos_y_q + YW'(1);
				end
			end else begin
				pos_x_q <= pos_x_q + XW'(1);
			end
		end
	end

endmodule

// ===== design/vmd_back.sv =====
// Back end: read-modify-write of the partial sums and result formation.
module vmd_back #(
	parameter int unsigned AW = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [AW-1:0]              in_addr,
	input  vmd_pkg::vox_ctl_t          in_ctl,
	input  vmd_pkg::in_item_t          in_item,
	input  logic [vmd_pkg::CcntW-1:0]  nch,
	output logic                       out_valid,
	input  logic                       out_ready,
	output vmd_pkg::out_item_t         out_item
);
	import vmd_pkg::*;

	localparam int unsigned Depth = 1 << AW;

	logic [SumW-1:0] mem_q [NumCh][Depth];

	// stage 1: memory read under way
	logic                     v_s1;
	logic [AW-1:0]            addr_s1;
	vox_ctl_t                 ctl_s1;
	logic signed [ChanW-1:0]  val_s1 [NumCh];
	logic [SumW-1:0]          rd_s1 [NumCh];
	// forwarding from the write of the previous voxel
	logic                     wv_q;
	logic [AW-1:0]            waddr_q;
	logic [SumW-1:0]          wdat_q [NumCh];
	logic [SumW-1:0]          sum [NumCh];
	logic [ChanW-1:0]         avg [NumCh];
	logic                     adv;
	logic                     emit;

	// output register with one skid entry
	logic                     ov_q, sv_q;
	out_item_t                o_q, s_q, nxt;

	assign in_ready = ~sv_q;
	assign adv      = in_valid & in_ready;
	assign emit     = v_s1 & ctl_s1.last;

	always_comb begin
		for (int c = 0; c < NumCh; c++) begin
			logic [SumW-1:0] base;
			base = (wv_q && waddr_q == addr_s1) ? wdat_q[c] : rd_s1[c];
			sum[c] = (ctl_s1.first ? '0 : base) + SumW'(val_s1[c]);
			avg[c] = (32'(c) < 32'(nch)) ? sum[c][SumW-1:3] : '0;
		end
		nxt.avg_a      = avg[0];
		nxt.avg_b      = avg[1];
		nxt.avg_c      = avg[2];
		nxt.avg_d      = avg[3];
		nxt.level_done = ctl_s1.done;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1 <= in_addr;
			ctl_s1  <= in_ctl;
			val_s1[0] <= in_item.chan_a;
			val_s1[1] <= (nch > CcntW'(1)) ? in_item.chan_b : '0;
			val_s1[2] <= (nch > CcntW'(2)) ? in_item.chan_c : '0;
			val_s1[3] <= (nch > CcntW'(3)) ? in_item.chan_d : '0;
			for (int c = 0; c < NumCh; c++) rd_s1[c] <= mem_q[c][in_addr];
		end
		if (v_s1) begin
			waddr_q <= addr_s1;
			for (int c = 0; c < NumCh; c++) begin
				wdat_q[c] <= sum[c];
				mem_q[c][addr_s1] <= sum[c];
			end
		end
		if (emit && (!ov_q || out_ready)) o_q <= nxt;
		else if (ov_q && out_ready && sv_q) o_q <= s_q;
		if (emit && ov_q && !out_ready) s_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			wv_q <= 1'b0;
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			// stage 1 never holds: it drains into the memory write every cycle
			v_s1 <= adv;
			wv_q <= v_s1 & ~adv ? 1'b0 : v_s1;
			if (ov_q && out_ready) begin
				ov_q <= sv_q | emit;
				sv_q <= 1'b0;
			end else if (emit) begin
				if (ov_q) sv_q <= 1'b1;
				ov_q <= 1'b1;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_item  = o_q;

endmodule

// ===== design/volume_mip_downsample_box_unit.sv =====
// Top level of the 2x2x2 box-filter volume mip downsampler.
// Source voxels enter one request per cycle in raster order (x, then y, then z);
// each request carries up to four signed Q16.16 channels. A partial-sum memory
// of MAX_HALF_WIDTH*MAX_HALF_HEIGHT entries per channel holds sums for the
// current slice pair; the memory does one read-modify-write per voxel, so the
// block sustains one voxel per cycle; the result of a block is formed from its
// eighth voxel in stage 1, then registered into the output register or skid entry.
// Memory contents need no clearing: the first voxel of every block overwrites its
// entry. A register write restarts the level. The output register plus one skid
// entry keep input flowing while a result waits; input stalls only with both full.
module volume_mip_downsample_box_unit #(
	parameter int unsigned MAX_HALF_WIDTH  = 128,
	parameter int unsigned MAX_HALF_HEIGHT = 128,
	parameter int unsigned MAX_HALF_DEPTH  = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vmd_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output vmd_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import vmd_pkg::*;

	// coordinates keep at least two bits so the destination index is never empty
	localparam int unsigned XW = $clog2(2*MAX_HALF_WIDTH) < 2 ? 2 : $clog2(2*MAX_HALF_WIDTH);
	localparam int unsigned YW = $clog2(2*MAX_HALF_HEIGHT) < 2 ? 2 : $clog2(2*MAX_HALF_HEIGHT);
	localparam int unsigned ZW = $clog2(2*MAX_HALF_DEPTH) < 2 ? 2 : $clog2(2*MAX_HALF_DEPTH);
	localparam int unsigned AW = (XW-1) + (YW-1) > 0 ? (XW-1) + (YW-1) : 1;

	logic [DimW-1:0]  hw_q, hh_q, hd_q;
	logic [CcntW-1:0] cc_q, nch;
	logic [XW-2:0]    dx;
	logic [YW-2:0]    dy;
	vox_ctl_t         ctl;
	logic             acc;
	logic [AW-1:0]    addr;

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= DimW'(1);
			hh_q <= DimW'(1);
			hd_q <= DimW'(1);
			cc_q <= CcntW'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HALF_WIDTH:    hw_q <= cfg_data;
				REG_HALF_HEIGHT:   hh_q <= cfg_data;
				REG_HALF_DEPTH:    hd_q <= cfg_data;
				REG_CHANNEL_COUNT: cc_q <= cfg_data[CcntW-1:0];
				default: ;
			endcase
		end
	end

	// zero channels acts as one, above four acts as four
	assign nch  = (cc_q == '0) ? CcntW'(1) : (cc_q > CcntW'(4)) ? CcntW'(4) : cc_q;
	assign acc  = in_valid & in_ready;
	assign addr = AW'({dy, dx});

	vmd_front #(
		.MaxHw(MAX_HALF_WIDTH), .MaxHh(MAX_HALF_HEIGHT), .MaxHd(MAX_HALF_DEPTH),
		.XW(XW), .YW(YW), .ZW(ZW)
	) u_front (
		.clk, .arst_n,
		.restart(cfg_we),
		.half_width(hw_q), .half_height(hh_q), .half_depth(hd_q),
		.step(acc),
		.dst_x(dx), .dst_y(dy), .ctl(ctl)
	);

	vmd_back #(.AW(AW)) u_back (
		.clk, .arst_n,
		.in_valid, .in_ready,
		.in_addr(addr), .in_ctl(ctl), .in_item(in_data), .nch(nch),
		.out_valid, .out_ready, .out_item(out_data)
	);

	// a request is never taken while both result slots are full
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !in_ready) |-> !acc)
		else $error("request taken with result slots full");
	// level_done on a shown result implies a shown result; this property holds trivially
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.level_done) |-> out_valid)
		else $error("level_done without result");
	// a result waiting unaccepted keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("waiting result changed");

endmodule

// ===== sim/volume_mip_downsample_box_unit_tb.sv =====
// Self-checking testbench for the 2x2x2 box-filter volume mip downsampler.
module volume_mip_downsample_box_unit_tb;
	import vmd_pkg::*;

	localparam int unsigned MaxHw = 128;
	localparam int unsigned MaxHh = 128;
	localparam int unsigned MaxHd = 128;
	localparam int unsigned StallLimit = 20000;
	localparam int unsigned RandItems = 480;
	localparam int unsigned DirRows = 16;
	localparam int unsigned HoldCycles = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	volume_mip_downsample_box_unit #(
		.MAX_HALF_WIDTH(MaxHw), .MAX_HALF_HEIGHT(MaxHh), .MAX_HALF_DEPTH(MaxHd)
	) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: register copies, raster position, slice-pair partial sums.
	logic [7:0] reg_hw, reg_hh, reg_hd;
	logic [2:0] reg_cc;
	int unsigned px, py, pz;
	logic signed [SumW-1:0] pair_sums [NumCh][MaxHw*MaxHh];

	out_item_t avg_queue[$];
	int unsigned err_count = 0;
	int unsigned idle_cycles = 0;
	bit hold_off = 1'b0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		err_count++;
	endtask

	function automatic int unsigned clamp_dim(input logic [7:0] v, input int unsigned mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic void set_reg(input reg_idx_t idx, input logic [7:0] val);
		case (idx)
			REG_HALF_WIDTH: begin
				reg_hw = val;
			end
			REG_HALF_HEIGHT: begin
				reg_hh = val;
			end
			REG_HALF_DEPTH: begin
				reg_hd = val;
			end
			default: begin
				reg_cc = val[2:0];
			end
		endcase
		px = 0;
		py = 0;
		pz = 0;
	endfunction

	// Fold one voxel into its destination sum; queue an average when a block closes.
	function automatic void predict_voxel(input in_item_t vox);
		int unsigned sw, sh, sd, nch, idx;
		bit first, last;
		logic signed [ChanW-1:0] ch [NumCh];
		logic signed [SumW-1:0] s;
		out_item_t res;
		sw = 2 * clamp_dim(reg_hw, MaxHw);
		sh = 2 * clamp_dim(reg_hh, MaxHh);
		sd = 2 * clamp_dim(reg_hd, MaxHd);
		nch = (reg_cc == 0) ? 1 : (reg_cc > 4) ? 4 : reg_cc;
		idx = (py / 2) * MaxHw + px / 2;
		first = ((px | py | pz) & 1) == 0;
		last = (px & py & pz & 1) != 0;
		ch[0] = vox.chan_a;
		ch[1] = vox.chan_b;
		ch[2] = vox.chan_c;
		ch[3] = vox.chan_d;
		res = '0;
		for (int c = 0; c < NumCh; c++) begin
			s = (c < nch) ? SumW'(ch[c]) : '0;
			if (!first) s = s + pair_sums[c][idx];
			pair_sums[c][idx] = s;
			if (last && c < nch) begin
				case (c)
					0: res.avg_a = ChanW'(s >>> 3);
					1: res.avg_b = ChanW'(s >>> 3);
					2: res.avg_c = ChanW'(s >>> 3);
					default: res.avg_d = ChanW'(s >>> 3);
				endcase
			end
		end
		if (last) begin
			res.level_done = (px == sw - 1) && (py == sh - 1) && (pz == sd - 1);
			avg_queue.push_back(res);
		end
		px++;
		if (px >= sw) begin
			px = 0;
			py++;
			if (py >= sh) begin
				py = 0;
				pz++;
				if (pz >= sd) pz = 0;
			end
		end
	endfunction

	function automatic logic [31:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Drive one request and hold it until the block takes it.
	task automatic send_voxel(input in_item_t vox);
		in_valid <= 1'b1;
		in_data <= vox;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_voxel(vox);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		in_data <= '0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain results and let the pipeline settle before touching registers.
	task automatic wait_idle();
		drop_valid();
		while (avg_queue.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(input logic [7:0] hw, input logic [7:0] hh,
			input logic [7:0] hd, input logic [2:0] cc);
		wait_idle();
		write_reg(REG_HALF_WIDTH, hw);
		write_reg(REG_HALF_HEIGHT, hh);
		write_reg(REG_HALF_DEPTH, hd);
		write_reg(REG_CHANNEL_COUNT, {5'd0, cc});
	endtask

	// Send voxels with bursty gaps on the sender side.
	task automatic send_levels(input int unsigned nvox);
		in_item_t vox;
		int unsigned burst;
		burst = $urandom_range(1, 40);
		for (int unsigned n = 0; n < nvox; n++) begin
			vox = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
			send_voxel(vox);
			if (--burst == 0) begin
				drop_valid();
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst = $urandom_range(1, 40);
			end
		end
	endtask

	// Directed voxel table: extremes on every channel, one 2x2x2 block per group of 8.
	in_item_t dir_vox [DirRows];
	out_item_t dir_want;

	// Receiver: own stall pattern, plus one long hold-off counted here.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
			end
		end
	end

	// Check each result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (avg_queue.size() == 0) begin
				report("unexpected result", out_data.avg_a, '0);
			end else begin
				dir_want = avg_queue.pop_front();
				if (out_data.avg_a !== dir_want.avg_a) report("avg_a", out_data.avg_a, dir_want.avg_a);
				if (out_data.avg_b !== dir_want.avg_b) report("avg_b", out_data.avg_b, dir_want.avg_b);
				if (out_data.avg_c !== dir_want.avg_c) report("avg_c", out_data.avg_c, dir_want.avg_c);
				if (out_data.avg_d !== dir_want.avg_d) report("avg_d", out_data.avg_d, dir_want.avg_d);
				if (out_data.level_done !== dir_want.level_done)
					report("level_done", out_data.level_done, dir_want.level_done);
			end
		end
	end

	// Watchdog: count cycles with no request moving on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		reg_hw = 1;
		reg_hh = 1;
		reg_hd = 1;
		reg_cc = 1;
		px = 0;
		py = 0;
		pz = 0;
		for (int r = 0; r < DirRows; r++) begin
			if (r < 8) dir_vox[r] = {4{32'h8000_0000}};
			else dir_vox[r] = {4{32'h7fff_ffff}};
		end
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset config (one channel), then all four channels at the extremes.
		for (int r = 0; r < DirRows; r++) begin
			if (r == 8) configure(1, 1, 1, 3'd4);
			send_voxel(dir_vox[r]);
			if (r == 7 || r == DirRows - 1) begin
				dir_want = avg_queue[avg_queue.size() - 1];
				if (r == 7 && (dir_want.avg_a !== 32'h8000_0000 || dir_want.avg_b !== '0))
					report("directed min", dir_want.avg_a, 32'h8000_0000);
				if (r == DirRows - 1 && dir_want.avg_d !== 32'h7fff_ffff)
					report("directed max", dir_want.avg_d, 32'h7fff_ffff);
			end
		end
		// Out-of-range settings: zero dims act as one, oversized clamp, odd channel counts.
		configure(0, 0, 0, 3'd0);
		send_levels(16);
		configure(1, 1, 1, 3'd7);
		send_levels(8);
		configure(255, 1, 1, 3'd5);
		send_levels(2 * 128 * 2 * 2);

		// Long receiver hold-off while the sender keeps pushing.
		configure(2, 2, 2, 3'd3);
		hold_off = 1'b1;
		send_levels(64);

		// Random phases: small volumes mostly, each with a fresh config.
		for (int unsigned sent = 0; sent < RandItems; ) begin
			int unsigned hw, hh, hd, nv;
			hw = $urandom_range(1, 4);
			hh = $urandom_range(1, 4);
			hd = $urandom_range(1, 3);
			configure(8'(hw), 8'(hh), 8'(hd), 3'($urandom_range(0, 7)));
			nv = 8 * hw * hh * hd * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0) nv = nv - $urandom_range(1, 7);
			send_levels(nv);
			sent += nv;
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (err_count == 0 && avg_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
